// ----- rtl/tsbr_pkg.sv -----
// ----------------------------------------------------------------------------
// tsbr_pkg
// Shared types and constants of the telemetry sensor bus responder.
// ----------------------------------------------------------------------------
package tsbr_pkg;

    // Request frame layout
    localparam logic [7:0]  REQ_LEN     = 8'h04;   // length byte of a request
    localparam logic [7:0]  RESP_LEN    = 8'h06;   // length byte of a long response
    localparam logic [7:0]  TYPE_TAIL   = 8'h02;   // last body byte of a type reply
    localparam logic [15:0] CKSUM_BASE  = 16'hFFFF;
    localparam logic [3:0]  ADDR_LIMIT  = 4'd4;

    // Command nibble of the second request byte
    localparam logic [3:0]  CMD_DISCOVER = 4'h8;
    localparam logic [3:0]  CMD_TYPE     = 4'h9;
    localparam logic [3:0]  CMD_MEASURE  = 4'hA;

    // Input item commands
    localparam logic        ITEM_RX_BYTE = 1'b0;
    localparam logic        ITEM_SET     = 1'b1;

    // Result kinds
    localparam logic        KIND_BYTE    = 1'b0;
    localparam logic        KIND_STATUS  = 1'b1;

    // Set-sensor status codes
    localparam logic [1:0]  ST_UPDATED   = 2'd0;
    localparam logic [1:0]  ST_ADDED     = 2'd1;
    localparam logic [1:0]  ST_FULL      = 2'd2;

    // Response burst buffer
    localparam int          MAX_RESULTS  = 6;
    localparam int          CNT_W        = $clog2(MAX_RESULTS + 1);

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] set_status;
    } t_result;

endpackage

// ----- rtl/telemetry_sensor_bus_responder.sv -----
// ----------------------------------------------------------------------------
// telemetry_sensor_bus_responder
// Sensor side of a half-duplex servo telemetry bus: frames requests, answers
// discovery, type and measurement commands, and keeps the sensor slot table.
// ----------------------------------------------------------------------------
// Each accepted item is handled in the cycle it is taken; its results are
// loaded into a six-entry response buffer that feeds the output register one
// result per cycle while the output is not stalled. A bus byte that answers
// nothing loads no results, so such bytes stream back to back. An item with
// results holds o_stall high while the buffer drains, so the next item is
// taken only once its last result has moved to the output register.
// Output stalls extend the drain.
// packet_start forces a byte to be taken as the first byte of a frame.
module telemetry_sensor_bus_responder #(
    parameter int SLOT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_packet_start,
    input  logic [7:0]  i_sensor_type,
    input  logic [15:0] i_sensor_value,
    // result side
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [1:0]  o_set_status
);
    import tsbr_pkg::*;

    // Slot table
    logic [7:0]  r_slot_type    [SLOT_COUNT];
    logic [15:0] r_slot_reading [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_slot_filled;
    logic [7:0]  n_slot_type    [SLOT_COUNT];
    logic [15:0] n_slot_reading [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] n_slot_filled;

    // Framing
    logic [7:0]  r_frame [3];
    logic [7:0]  n_frame [3];
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;

    // Response buffer and output register
    t_result     r_buf [MAX_RESULTS];
    t_result     n_buf [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_result     r_out;
    logic        r_out_valid;

    logic        accept;
    logic        move;

    assign o_stall = (r_cnt != '0);
    assign accept  = i_valid & ~o_stall;
    assign move    = (r_cnt != '0) & (~r_out_valid | ~i_stall);

    // Item processing: framing, frame judgment, slot table update
    always_comb begin
        logic [1:0]  pos_eff;
        logic [7:0]  f0, f1;
        logic [15:0] expect_sum;
        logic [15:0] got_sum;
        logic [3:0]  addr;
        logic [3:0]  op;
        logic        sel_filled;
        logic [7:0]  sel_type;
        logic [15:0] sel_reading;
        logic        answer;
        logic [7:0]  body [4];
        logic [2:0]  body_len;
        logic [15:0] sum;
        logic [15:0] cksum;
        logic        hit;
        logic        free;
        logic [1:0]  status;

        n_slot_type    = r_slot_type;
        n_slot_reading = r_slot_reading;
        n_slot_filled  = r_slot_filled;
        n_frame        = r_frame;
        n_pos          = r_pos;
        n_buf          = r_buf;
        n_cnt          = r_cnt;

        pos_eff     = i_packet_start ? 2'd0 : r_pos;
        f0          = r_frame[0];
        f1          = r_frame[1];
        expect_sum  = CKSUM_BASE - {8'h00, f0} - {8'h00, f1};
        got_sum     = {i_rx_byte, r_frame[2]};
        addr        = f1[3:0];
        op          = f1[7:4];
        sel_filled  = 1'b0;
        sel_type    = '0;
        sel_reading = '0;
        answer      = 1'b0;
        body        = '{default: 8'h00};
        body_len    = 3'd4;
        hit         = 1'b0;
        free        = 1'b0;
        status      = ST_FULL;

        // slot addressed by the request
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (addr == 4'(i + 1)) begin
                sel_filled  = r_slot_filled[i];
                sel_type    = r_slot_type[i];
                sel_reading = r_slot_reading[i];
            end
        end

        // response body
        unique case (op)
            CMD_DISCOVER: begin
                answer   = 1'b1;
                body[0]  = REQ_LEN;
                body[1]  = {CMD_DISCOVER, addr};
                body_len = 3'd2;
            end
            CMD_TYPE: begin
                answer  = 1'b1;
                body[0] = RESP_LEN;
                body[1] = {CMD_TYPE, addr};
                body[2] = sel_type;
                body[3] = TYPE_TAIL;
            end
            CMD_MEASURE: begin
                answer  = 1'b1;
                body[0] = RESP_LEN;
                body[1] = {CMD_MEASURE, addr};
                body[2] = sel_reading[7:0];
                body[3] = sel_reading[15:8];
            end
            default: begin
                answer = 1'b0;
            end
        endcase

        answer = answer & (f0 == REQ_LEN) & (expect_sum == got_sum)
               & (addr != 4'd0) & (addr <= ADDR_LIMIT) & sel_filled;

        sum   = {8'h00, body[0]} + {8'h00, body[1]} + {8'h00, body[2]}
              + {8'h00, body[3]};
        cksum = CKSUM_BASE - sum;

        if (accept && i_cmd == ITEM_SET) begin
            // update a matching slot, else fill the first empty one
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!hit && r_slot_filled[i] && r_slot_type[i] == i_sensor_type) begin
                    n_slot_reading[i] = i_sensor_value;
                    hit = 1'b1;
                end
            end
            if (hit) begin
                status = ST_UPDATED;
            end else begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!free && !r_slot_filled[i]) begin
                        n_slot_type[i]    = i_sensor_type;
                        n_slot_reading[i] = i_sensor_value;
                        n_slot_filled[i]  = 1'b1;
                        free = 1'b1;
                    end
                end
                status = free ? ST_ADDED : ST_FULL;
            end
            n_buf[0] = '{kind: KIND_STATUS, tx_byte: 8'h00, last: 1'b1,
                         set_status: status};
            n_cnt    = CNT_W'(1);
        end else if (accept) begin
            // bus byte: store or complete the frame
            if (pos_eff != 2'd3) begin
                n_frame[pos_eff] = i_rx_byte;
                n_pos            = pos_eff + 2'd1;
            end else begin
                n_pos = 2'd0;
                if (answer) begin
                    for (int k = 0; k < MAX_RESULTS; k++) begin
                        n_buf[k] = '{kind: KIND_BYTE, tx_byte: 8'h00, last: 1'b0,
                                     set_status: ST_UPDATED};
                        if (k < 4 && 3'(k) < body_len) begin
                            n_buf[k].tx_byte = body[k % 4];
                        end else if (3'(k) == body_len) begin
                            n_buf[k].tx_byte = cksum[7:0];
                        end else if (3'(k) == body_len + 3'd1) begin
                            n_buf[k].tx_byte = cksum[15:8];
                            n_buf[k].last    = 1'b1;
                        end
                    end
                    n_cnt = CNT_W'(body_len) + CNT_W'(2);
                end
            end
        end else if (move) begin
            // shift the next result toward the output register
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                n_buf[k] = r_buf[k + 1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    // Control state and slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_type[i]    <= 8'hFF;
                r_slot_reading[i] <= 16'h0000;
            end
            r_slot_filled <= '0;
            r_pos         <= 2'd0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_slot_type    <= n_slot_type;
            r_slot_reading <= n_slot_reading;
            r_slot_filled  <= n_slot_filled;
            r_pos          <= n_pos;
            r_cnt          <= n_cnt;
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_buf   <= n_buf;
        if (move) begin
            r_out <= r_buf[0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_tx_byte    = r_out.tx_byte;
    assign o_last       = r_out.last;
    assign o_set_status = r_out.set_status;

endmodule

// ----- rtl/tsbr_checker.sv -----
// ----------------------------------------------------------------------------
// tsbr_checker
// Port-level checks of the telemetry sensor bus responder, bound to the top.
// ----------------------------------------------------------------------------
module tsbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_cmd,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_kind,
    input logic [7:0]  o_tx_byte,
    input logic        o_last,
    input logic [1:0]  o_set_status
);
    import tsbr_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tx_byte) && $stable(o_kind)
                               && $stable(o_last) && $stable(o_set_status))
        else $error("stalled result changed");

    // a status result is a single, final transfer with no bus byte
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS |-> o_last && o_tx_byte == 8'h00)
        else $error("malformed status result");

    // a bus byte carries no status
    a_byte_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_BYTE |-> o_set_status == ST_UPDATED)
        else $error("bus byte carries status");

    // status code is one of the three defined outcomes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_set_status == ST_UPDATED || o_set_status == ST_ADDED
                    || o_set_status == ST_FULL)
        else $error("undefined status code");

    // a set-sensor transfer always produces a result, so input stalls after it
    a_set_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_cmd == ITEM_SET |=> o_stall)
        else $error("set-sensor transfer produced no result");

endmodule

bind telemetry_sensor_bus_responder tsbr_checker u_tsbr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_cmd        (i_cmd),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_tx_byte    (o_tx_byte),
    .o_last       (o_last),
    .o_set_status (o_set_status)
);
